// ===== rtl/core/lfu_pkg.sv =====
// lfu_pkg: shared types and constants for the lfu cache table
// no dependencies; used by every module under rtl/core
package lfu_pkg;
	localparam int ENTRIES     = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int OCC_W       = $clog2(ENTRIES + 1);
	localparam int CAP_W       = 5;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] key;
		logic [31:0] value;
	} lfu_in_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] read_value;
	} lfu_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch request, clear scan
		logic scan;      // examine entry at scan index
		logic clr_scan;  // restart scan index
		logic evict;     // drop the victim
		logic touch;     // update matched entry
		logic insert;    // fill first free entry
		logic respond;   // drive result strobe
	} lfu_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic is_put;
		logic found;
		logic cap_zero;
		logic full;
		logic have_victim;
		logic have_free;
	} lfu_sts_t;
endpackage

// ===== rtl/core/lfu_ctrl.sv =====
// lfu_ctrl: sequencer for lookup, eviction and fill
// depends on lfu_pkg
module lfu_ctrl import lfu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  lfu_sts_t sts,
	output lfu_cmd_t cmd
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_EVICT = 3'd3;
	localparam logic [2:0] S_SCAN2 = 3'd4;
	localparam logic [2:0] S_FILL  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) state_d = S_DEC;
			end
			S_DEC: begin
				if (sts.found) begin
					if (!(sts.is_put && sts.cap_zero)) cmd.touch = 1'b1;
					state_d = S_DONE;
				end else if (!sts.is_put || sts.cap_zero) begin
					state_d = S_DONE;
				end else if (sts.full && sts.have_victim) begin
					state_d = S_EVICT;
				end else begin
					state_d = S_FILL;
				end
			end
			S_EVICT: begin
				cmd.evict = 1'b1;
				cmd.clr_scan = 1'b1;
				state_d = S_SCAN2;
			end
			S_SCAN2: begin
				// rescan to find the lowest free slot
				cmd.scan = 1'b1;
				if (sts.scan_last) state_d = S_FILL;
			end
			S_FILL: begin
				if (sts.have_free) cmd.insert = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.respond = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== rtl/core/lfu_dpath.sv =====
// lfu_dpath: entry storage, serial scan for match, victim and free slot
// depends on lfu_pkg
module lfu_dpath import lfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lfu_cmd_t         cmd,
	input  lfu_in_t          req,
	input  logic [CAP_W-1:0] capacity,
	output lfu_sts_t         sts,
	output logic             res_valid,
	output lfu_out_t         res
);
	logic [ENTRIES-1:0]     valid_q;
	logic [31:0]            key_q   [ENTRIES];
	logic [31:0]            data_q  [ENTRIES];
	logic [COUNT_WIDTH-1:0] cnt_q   [ENTRIES];
	logic [IDX_W-1:0]       rank_q  [ENTRIES];
	logic [OCC_W-1:0]       occ_q;

	lfu_in_t                req_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   found_q, vic_ok_q, free_ok_q;
	logic [IDX_W-1:0]       match_q, vic_q, free_q;
	logic [31:0]            rdata_q;
	logic                   res_valid_q;
	lfu_out_t               res_q;

	logic [OCC_W-1:0] cap_eff;
	assign cap_eff = (capacity > CAP_W'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(capacity);

	logic                   last;
	logic                   better;
	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [IDX_W-1:0]       cur_rank;
	assign last     = (idx_q == IDX_W'(ENTRIES - 1));
	assign cur_cnt  = cnt_q[idx_q];
	assign cur_rank = rank_q[idx_q];
	assign better   = !vic_ok_q || (cur_cnt < cnt_q[vic_q]) ||
	                  (cur_cnt == cnt_q[vic_q] && cur_rank > rank_q[vic_q]);

	assign sts.scan_last   = last;
	assign sts.is_put      = (req_q.opcode == OP_PUT);
	assign sts.found       = found_q;
	assign sts.cap_zero    = (cap_eff == '0);
	assign sts.full        = (occ_q >= cap_eff);
	assign sts.have_victim = vic_ok_q;
	assign sts.have_free   = free_ok_q;

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			found_q   <= 1'b0;
			vic_ok_q  <= 1'b0;
			free_ok_q <= 1'b0;
			match_q   <= '0;
			vic_q     <= '0;
			free_q    <= '0;
		end else if (cmd.load) begin
			idx_q     <= '0;
			found_q   <= 1'b0;
			vic_ok_q  <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (cmd.clr_scan) begin
			idx_q     <= '0;
			free_ok_q <= 1'b0;
		end else if (cmd.scan) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
			if (valid_q[idx_q]) begin
				if (key_q[idx_q] == req_q.key && !found_q) begin
					found_q <= 1'b1;
					match_q <= idx_q;
				end
				if (better) begin
					vic_ok_q <= 1'b1;
					vic_q    <= idx_q;
				end
			end else if (!free_ok_q) begin
				free_ok_q <= 1'b1;
				free_q    <= idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.scan && valid_q[idx_q] && key_q[idx_q] == req_q.key && !found_q)
			rdata_q <= data_q[idx_q];
	end

	// entry updates; rank shifts are checked on every valid lane in parallel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (cmd.evict) begin
			valid_q[vic_q] <= 1'b0;
			if (occ_q != '0) occ_q <= occ_q - 1'b1;
		end else if (cmd.insert) begin
			valid_q[free_q] <= 1'b1;
			occ_q <= occ_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < ENTRIES; j++) begin
			if (cmd.evict && valid_q[j] && rank_q[j] > rank_q[vic_q])
				rank_q[j] <= rank_q[j] - 1'b1;
			if (cmd.touch && valid_q[j] && rank_q[j] < rank_q[match_q])
				rank_q[j] <= rank_q[j] + 1'b1;
			if (cmd.insert && valid_q[j])
				rank_q[j] <= rank_q[j] + 1'b1;
		end
		if (cmd.touch) begin
			rank_q[match_q] <= '0;
			if (cnt_q[match_q] != COUNT_MAX) cnt_q[match_q] <= cnt_q[match_q] + 1'b1;
			if (req_q.opcode == OP_PUT) data_q[match_q] <= req_q.value;
		end
		if (cmd.insert) begin
			key_q[free_q]  <= req_q.key;
			data_q[free_q] <= req_q.value;
			cnt_q[free_q]  <= COUNT_WIDTH'(1);
			rank_q[free_q] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else res_valid_q <= cmd.respond;
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			res_q.hit        <= found_q;
			res_q.read_value <= (found_q && req_q.opcode == OP_GET) ? rdata_q : 32'd0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule

// ===== rtl/core/lfu_cache_table_top.sv =====
// lfu_cache_table_top: 16-entry lfu cache, lru among equal counts
// a put that evicts rescans for the free slot; serial scan, one item at a time.
// result strobe lasts one cycle and cannot be held off by the receiver.
// reset empties the table and sets capacity to 16; no clearing pass.
// depends on lfu_pkg, lfu_ctrl, lfu_dpath
module lfu_cache_table_top import lfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  lfu_in_t          req,
	output logic             done,
	output lfu_out_t         result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);
	lfu_cmd_t         cmd;
	lfu_sts_t         sts;
	logic [CAP_W-1:0] cap_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_W'(16);
		else if (cfg_valid && cfg_ready) cap_q <= cfg_data;
	end

	lfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	lfu_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(req), .capacity(cap_q),
		.sts(sts), .res_valid(done), .res(result)
	);
endmodule
